// ===== rtl/core/drec_pkg.sv =====
package drec_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int TAG_W   = 16;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // year, month, day concatenated so unsigned order is date order
  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {r.year, r.month, r.day};
  endfunction

endpackage

// ===== rtl/core/drec_ram.sv =====
module drec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/date_record_exchange_sorter_top.sv =====
// Loads N records (one per cycle), then sorts and emits them. One
// compare-swap per cycle, set by the single write / single read port of
// the record RAM; no input is taken meanwhile.
// rst_n is synchronous, active low: clears the sequencer and record count.
// The record RAM is not cleared; only entries written in the current set are read.
module date_record_exchange_sorter_top #(
  parameter int MAX_RECORDS = drec_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [drec_pkg::DAY_W-1:0]   in_day,
  input  logic [drec_pkg::MONTH_W-1:0] in_month,
  input  logic [drec_pkg::YEAR_W-1:0]  in_year,
  input  logic [drec_pkg::TAG_W-1:0]   in_tag,
  input  logic                       in_last,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [drec_pkg::DAY_W-1:0]   out_day,
  output logic [drec_pkg::MONTH_W-1:0] out_month,
  output logic [drec_pkg::YEAR_W-1:0]  out_year,
  output logic [drec_pkg::TAG_W-1:0]   out_tag,
  output logic                       out_last
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LD_I,
    S_CMP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;
  drec_pkg::rec_t cur_r, cur_nxt;

  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  drec_pkg::rec_t            ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [drec_pkg::REC_W-1:0] ram_rdata;
  drec_pkg::rec_t            rd_rec;
  drec_pkg::rec_t            in_rec;

  assign in_rec = '{day: in_day, month: in_month, year: in_year, tag: in_tag};
  assign rd_rec = drec_pkg::rec_t'(ram_rdata);
  assign i_inc  = i_r + CW'(1);
  assign j_inc  = j_r + CW'(1);

  drec_ram #(
    .WIDTH (drec_pkg::REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry i is held in cur_r while j sweeps the rest; a swap writes cur_r
  // back at j. After the sweep cur_r holds the final entry i and is emitted.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = in_rec;
    ram_raddr     = i_r[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_RECORDS)) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_last) begin
            i_nxt     = '0;
            state_nxt = S_RD_I;
          end
        end
      end
      S_RD_I: begin
        state_nxt = S_LD_I;
      end
      S_LD_I: begin
        cur_nxt   = rd_rec;
        ram_raddr = i_inc[AW-1:0];
        j_nxt     = i_inc;
        if (i_inc < cnt_r) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt     = S_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      S_CMP: begin
        // read of j+1 overlaps the write-back at j
        ram_raddr = j_inc[AW-1:0];
        if (drec_pkg::rec_key(cur_r) > drec_pkg::rec_key(rd_rec)) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = cur_r;
          cur_nxt   = rd_rec;
        end
        if (j_inc < cnt_r) begin
          j_nxt = j_inc;
        end else begin
          state_nxt     = S_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (i_inc == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_RD_I;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_day   = cur_r.day;
  assign out_month = cur_r.month;
  assign out_year  = cur_r.year;
  assign out_tag   = cur_r.tag;
  assign out_last  = (i_inc == cnt_r);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECORDS))
    else $error("record count above store depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (j_r > i_r && j_r < cnt_r))
    else $error("compare index outside the sweep");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (!in_stall && cnt_r == '0))
    else $error("set not closed after final transaction");
`endif

endmodule
